[design/gmdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdl_pkg
// Shared types, constants and the corner offset table of the mesh list
// generator.
// ----------------------------------------------------------------------------
package gmdl_pkg;

    localparam int unsigned CoordW  = 16;
    localparam int unsigned SizeW   = 12;
    localparam int unsigned OpW     = 8;
    localparam int unsigned WordW   = 32;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [1:0] LastCorner = 2'd2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_SQUARE_WIDTH  = 3'd2,
        REG_SQUARE_HEIGHT = 3'd3,
        REG_IDENTITY      = 3'd4,
        REG_TRI_OPCODE    = 3'd5,
        REG_SYNC_OPCODE   = 3'd6,
        REG_TRAP_OPCODE   = 3'd7
    } t_reg_idx;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DIVC = 13'b0000000000010,
        S_DIVR = 13'b0000000000100,
        S_CNT  = 13'b0000000001000,
        S_HDR  = 13'b0000000010000,
        S_MX   = 13'b0000000100000,
        S_MY   = 13'b0000001000000,
        S_W0   = 13'b0000010000000,
        S_W1   = 13'b0000100000000,
        S_W2   = 13'b0001000000000,
        S_W3   = 13'b0010000000000,
        S_SYNC = 13'b0100000000000,
        S_TRAP = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic dcol;
        logic drow;
    } t_offset;

    // corner offsets of the even and odd triangle of a square
    function automatic t_offset corner_offset(input logic odd, input logic [1:0] corner);
        t_offset v;
        v = '{dcol: 1'b0, drow: 1'b0};
        if (!odd) begin
            unique case (corner)
                2'd0:    v = '{dcol: 1'b0, drow: 1'b1};
                2'd1:    v = '{dcol: 1'b0, drow: 1'b0};
                default: v = '{dcol: 1'b1, drow: 1'b0};
            endcase
        end else begin
            unique case (corner)
                2'd0:    v = '{dcol: 1'b1, drow: 1'b0};
                2'd1:    v = '{dcol: 1'b0, drow: 1'b1};
                default: v = '{dcol: 1'b1, drow: 1'b1};
            endcase
        end
        return v;
    endfunction

endpackage

[design/gmdl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdl_div
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module gmdl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gmdl_pkg::SizeW-1:0]    i_dividend,
    input  logic [gmdl_pkg::SizeW-1:0]    i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [gmdl_pkg::SizeW-1:0]    o_quotient
);

    localparam int unsigned W = gmdl_pkg::SizeW;

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [3:0]   r_cnt, n_cnt;
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_quo, n_quo;
    logic [W-1:0] r_dvs, n_dvs;
    logic [W:0]   w_shift;
    logic [W+1:0] w_diff;
    logic         w_ge;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_diff[W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            n_quo = {r_quo[W-2:0], w_ge};
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = (r_dvs == '0) ? '0 : r_quo;

endmodule

[design/grid_mesh_display_list_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mesh_display_list_generator
// Mesh display list generator: header, four words per vertex, trailer.
// ----------------------------------------------------------------------------
// One vertex word at a time. A vertex passes the accepting cycle, the shared
// 13x12 multiplier for the X and then the Y coordinate, then four list words
// at one per cycle while the output is not stalled. The first vertex of a list
// first runs two 12-step divisions on the shared divider for the square counts,
// a multiplier product for the vertex count and the header word. The last
// vertex adds the sync and trap words. Input stall stays high from acceptance
// until the last word of the vertex (for the last vertex, the trap word) sits
// in the output register; output stall holds the sequencer in its word states.
module grid_mesh_display_list_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [gmdl_pkg::CfgIdxW-1:0]           i_cfg_index,
    input  logic [gmdl_pkg::SizeW-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [gmdl_pkg::CoordW-1:0]            i_dest_x,
    input  logic [gmdl_pkg::CoordW-1:0]            i_dest_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [gmdl_pkg::WordW-1:0]             o_list_word,
    output logic                                   o_last_of_run,
    output logic                                   o_end_of_list
);

    localparam int unsigned SW = gmdl_pkg::SizeW;
    localparam int unsigned CW = gmdl_pkg::CoordW;
    localparam int unsigned OW = gmdl_pkg::OpW;

    // configuration
    logic [SW-1:0] r_img_w, r_img_h, r_sq_w, r_sq_h;
    logic          r_identity;
    logic [OW-1:0] r_tri_op, r_sync_op, r_trap_op;

    // sequencer and mesh position
    gmdl_pkg::t_state r_state, n_state;
    logic          r_started, n_started;
    logic [SW-1:0] r_col, n_col;
    logic [SW-1:0] r_row, n_row;
    logic          r_odd, n_odd;
    logic [1:0]    r_corner, n_corner;
    logic [SW-1:0] r_cc, n_cc;
    logic [SW-1:0] r_rr, n_rr;
    logic [CW-1:0] r_sx, n_sx;
    logic [CW-1:0] r_sy, n_sy;
    logic [CW-1:0] r_prod, n_prod;
    logic [CW-1:0] r_dx, n_dx;
    logic [CW-1:0] r_dy, n_dy;

    // output register
    logic                       r_ovalid, n_ovalid;
    logic [gmdl_pkg::WordW-1:0] r_word, n_word;
    logic                       r_last, n_last;
    logic                       r_end, n_end;

    logic                       w_in_acc;
    logic                       w_free;
    logic                       w_div_start;
    logic                       w_div_busy;
    logic                       w_div_done;
    logic [SW-1:0]              w_div_a, w_div_b, w_div_q;
    logic [SW:0]                w_mul_a;
    logic [SW-1:0]              w_mul_b;
    logic [2*SW:0]              w_mul_p;
    logic [CW-1:0]              w_verts;
    logic                       w_final;
    gmdl_pkg::t_offset          w_off;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_free   = !r_ovalid || !i_out_stall;
    assign w_off    = gmdl_pkg::corner_offset(r_odd, r_corner);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= SW'(1920);
            r_img_h    <= SW'(1080);
            r_sq_w     <= SW'(24);
            r_sq_h     <= SW'(24);
            r_identity <= 1'b1;
            r_tri_op   <= '0;
            r_sync_op  <= '0;
            r_trap_op  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (gmdl_pkg::t_reg_idx'(i_cfg_index))
                gmdl_pkg::REG_IMAGE_WIDTH:   r_img_w    <= i_cfg_data;
                gmdl_pkg::REG_IMAGE_HEIGHT:  r_img_h    <= i_cfg_data;
                gmdl_pkg::REG_SQUARE_WIDTH:  r_sq_w     <= i_cfg_data;
                gmdl_pkg::REG_SQUARE_HEIGHT: r_sq_h     <= i_cfg_data;
                gmdl_pkg::REG_IDENTITY:      r_identity <= i_cfg_data[0];
                gmdl_pkg::REG_TRI_OPCODE:    r_tri_op   <= i_cfg_data[OW-1:0];
                gmdl_pkg::REG_SYNC_OPCODE:   r_sync_op  <= i_cfg_data[OW-1:0];
                gmdl_pkg::REG_TRAP_OPCODE:   r_trap_op  <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // shared divider for the square counts
    assign w_div_start = (w_in_acc && !r_started) ||
                         ((r_state == gmdl_pkg::S_DIVC) && w_div_done);
    assign w_div_a     = (r_state == gmdl_pkg::S_DIVC) ? r_img_h : r_img_w;
    assign w_div_b     = (r_state == gmdl_pkg::S_DIVC) ? r_sq_h  : r_sq_w;

    gmdl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // shared multiplier
    always_comb begin
        unique case (r_state)
            gmdl_pkg::S_MX: begin
                w_mul_a = {1'b0, r_col} + {{SW{1'b0}}, w_off.dcol};
                w_mul_b = r_sq_w;
            end
            gmdl_pkg::S_MY: begin
                w_mul_a = {1'b0, r_row} + {{SW{1'b0}}, w_off.drow};
                w_mul_b = r_sq_h;
            end
            default: begin
                w_mul_a = {1'b0, r_cc};
                w_mul_b = r_rr;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_verts = (r_prod << 2) + (r_prod << 1);
    assign w_final = (r_corner == gmdl_pkg::LastCorner) && r_odd &&
                     ({1'b0, r_col} + 13'd1 >= {1'b0, r_cc}) &&
                     ({1'b0, r_row} + 13'd1 >= {1'b0, r_rr});

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_col     = r_col;
        n_row     = r_row;
        n_odd     = r_odd;
        n_corner  = r_corner;
        n_cc      = r_cc;
        n_rr      = r_rr;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_prod    = r_prod;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_ovalid  = r_ovalid && i_out_stall;
        n_word    = r_word;
        n_last    = r_last;
        n_end     = r_end;
        unique case (r_state)
            gmdl_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_dx    = i_dest_x;
                    n_dy    = i_dest_y;
                    n_state = r_started ? gmdl_pkg::S_MX : gmdl_pkg::S_DIVC;
                end
            end
            gmdl_pkg::S_DIVC: begin
                if (w_div_done) begin
                    n_cc    = w_div_q;
                    n_state = gmdl_pkg::S_DIVR;
                end
            end
            gmdl_pkg::S_DIVR: begin
                if (w_div_done) begin
                    n_rr    = w_div_q;
                    n_state = gmdl_pkg::S_CNT;
                end
            end
            gmdl_pkg::S_CNT: begin
                n_prod  = w_mul_p[CW-1:0];
                n_state = gmdl_pkg::S_HDR;
            end
            gmdl_pkg::S_HDR: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = {r_tri_op, {(gmdl_pkg::WordW-OW-CW){1'b0}}, w_verts};
                    n_last   = 1'b0;
                    n_end    = 1'b0;
                    n_col    = '0;
                    n_row    = '0;
                    n_odd    = 1'b0;
                    n_corner = '0;
                    if (r_cc == '0 || r_rr == '0) begin
                        n_state = gmdl_pkg::S_SYNC;
                    end else begin
                        n_started = 1'b1;
                        n_state   = gmdl_pkg::S_MX;
                    end
                end
            end
            gmdl_pkg::S_MX: begin
                n_sx    = w_mul_p[CW-1:0];
                n_state = gmdl_pkg::S_MY;
            end
            gmdl_pkg::S_MY: begin
                n_sy    = w_mul_p[CW-1:0];
                n_state = gmdl_pkg::S_W0;
            end
            gmdl_pkg::S_W0: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = {r_sx, r_sy};
                    n_last   = 1'b0;
                    n_end    = 1'b0;
                    n_state  = gmdl_pkg::S_W1;
                end
            end
            gmdl_pkg::S_W1: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = r_identity ? {r_sx, r_sy} : {r_dx, r_dy};
                    n_last   = 1'b0;
                    n_end    = 1'b0;
                    n_state  = gmdl_pkg::S_W2;
                end
            end
            gmdl_pkg::S_W2: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = '0;
                    n_last   = 1'b0;
                    n_end    = 1'b0;
                    n_state  = gmdl_pkg::S_W3;
                end
            end
            gmdl_pkg::S_W3: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = '0;
                    n_last   = !w_final;
                    n_end    = 1'b0;
                    if (r_corner != gmdl_pkg::LastCorner) begin
                        n_corner = r_corner + 2'd1;
                    end else begin
                        n_corner = '0;
                        n_odd    = !r_odd;
                        if (r_odd) begin
                            if (r_col + SW'(1) >= r_cc) begin
                                n_col = '0;
                                n_row = (r_row + SW'(1) >= r_rr) ? '0 : r_row + SW'(1);
                            end else begin
                                n_col = r_col + SW'(1);
                            end
                        end
                    end
                    if (w_final) begin
                        n_started = 1'b0;
                        n_state   = gmdl_pkg::S_SYNC;
                    end else begin
                        n_state = gmdl_pkg::S_IDLE;
                    end
                end
            end
            gmdl_pkg::S_SYNC: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = {r_sync_op, {(gmdl_pkg::WordW-OW){1'b0}}};
                    n_last   = 1'b0;
                    n_end    = 1'b0;
                    n_state  = gmdl_pkg::S_TRAP;
                end
            end
            gmdl_pkg::S_TRAP: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_word   = {r_trap_op, {(gmdl_pkg::WordW-OW){1'b0}}};
                    n_last   = 1'b1;
                    n_end    = 1'b1;
                    n_state  = gmdl_pkg::S_IDLE;
                end
            end
            default: n_state = gmdl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gmdl_pkg::S_IDLE;
            r_started <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_odd     <= 1'b0;
            r_corner  <= '0;
            r_cc      <= '0;
            r_rr      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_col     <= n_col;
            r_row     <= n_row;
            r_odd     <= n_odd;
            r_corner  <= n_corner;
            r_cc      <= n_cc;
            r_rr      <= n_rr;
            r_ovalid  <= n_ovalid;
        end
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_prod <= n_prod;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_word <= n_word;
        r_last <= n_last;
        r_end  <= n_end;
    end

    assign o_in_stall    = (r_state != gmdl_pkg::S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_list_word   = r_word;
    assign o_last_of_run = r_last;
    assign o_end_of_list = r_end;

    // checks
    a_trap_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_list |-> o_last_of_run)
        else $error("trap word without end of run");

    a_open_list_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_cc != '0) && (r_rr != '0))
        else $error("list open with empty mesh");

    a_position_in_mesh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_col < r_cc) && (r_row < r_rr) && (r_corner <= gmdl_pkg::LastCorner))
        else $error("mesh position out of range");

    a_new_list_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !r_started |=> w_div_busy && (r_state == gmdl_pkg::S_DIVC))
        else $error("new list without count division");

endmodule
